### rtl/gccc_pkg.sv
// Shared constants, codes and sequencer state type for the grid cell converter.
// No dependencies; used by gccc_div and grid_cell_coordinate_converter_core.
package gccc_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    localparam int POS_W  = 64;
    localparam int CELL_W = 32;
    localparam int SIZE_W = 63;
    localparam int DIV_CNT_W = $clog2(POS_W);

    typedef enum logic [1:0] {
        MODE_ABS  = 2'd0,
        MODE_CELL = 2'd1,
        MODE_NORM = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_BASE   = 3'd0,
        CFG_RATIO  = 3'd1,
        CFG_ORG_X  = 3'd2,
        CFG_ORG_Y  = 3'd3,
        CFG_ORG_Z  = 3'd4
    } cfg_idx_t;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_SZ     = 14'b00000000000010,
        ST_SZ_LO  = 14'b00000000000100,
        ST_SZ_HI  = 14'b00000000001000,
        ST_AX     = 14'b00000000010000,
        ST_MAC_LO = 14'b00000000100000,
        ST_MAC_HI = 14'b00000001000000,
        ST_ADD_P  = 14'b00000010000000,
        ST_SUB    = 14'b00000100000000,
        ST_DIV    = 14'b00001000000000,
        ST_CELL   = 14'b00010000000000,
        ST_LOC_LO = 14'b00100000000000,
        ST_LOC_HI = 14'b01000000000000,
        ST_DONE_W = 14'b10000000000000
    } state_t;

    // Saturating add of a signed 64-bit value and a signed-by-flag 64-bit magnitude.
    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] mag,
                                                 input logic neg);
        logic signed [POS_W+1:0] ext_a;
        logic signed [POS_W+1:0] ext_m;
        logic signed [POS_W+1:0] s;
        ext_a = signed'({{2{a[POS_W-1]}}, a});
        ext_m = signed'({2'b00, mag});
        s = neg ? (ext_a - ext_m) : (ext_a + ext_m);
        if (s[POS_W+1:POS_W-1] == 3'b000 || s[POS_W+1:POS_W-1] == 3'b111)
            sat_add = s[POS_W-1:0];
        else if (s[POS_W+1])
            sat_add = {1'b1, {(POS_W-1){1'b0}}};
        else
            sat_add = {1'b0, {(POS_W-1){1'b1}}};
    endfunction

endpackage

### rtl/gccc_div.sv
// Restoring divider, one quotient bit per cycle, for the grid cell converter.
// Depends on gccc_pkg for widths.
module gccc_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [gccc_pkg::POS_W-1:0]       dividend,
    input  logic [gccc_pkg::SIZE_W-1:0]      divisor,
    output logic                             done,
    output logic [gccc_pkg::POS_W-1:0]       quotient,
    output logic [gccc_pkg::SIZE_W-1:0]      remainder
);

    logic                                busy_reg;
    logic                                busy_next;
    logic                                done_reg;
    logic                                done_next;
    logic [gccc_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [gccc_pkg::DIV_CNT_W-1:0]      cnt_next;
    logic [gccc_pkg::POS_W-1:0]          quo_reg;
    logic [gccc_pkg::POS_W-1:0]          quo_next;
    logic [gccc_pkg::SIZE_W-1:0]         rem_reg;
    logic [gccc_pkg::SIZE_W-1:0]         rem_next;
    logic [gccc_pkg::SIZE_W-1:0]         div_reg;
    logic [gccc_pkg::SIZE_W-1:0]         div_next;
    logic [gccc_pkg::POS_W-1:0]          trial;
    logic [gccc_pkg::POS_W-1:0]          diff;
    logic                                ge;

    assign trial = {rem_reg, quo_reg[gccc_pkg::POS_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            quo_next = {quo_reg[gccc_pkg::POS_W-2:0], ge};
            rem_next = ge ? diff[gccc_pkg::SIZE_W-1:0] : trial[gccc_pkg::SIZE_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {gccc_pkg::DIV_CNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without a running division");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider busy at done");

endmodule

### rtl/grid_cell_coordinate_converter_core.sv
// Top level of the multi-level grid cell converter: sequencer, shared 32x32
// multiplier, saturating adder and config registers. Uses gccc_pkg, gccc_div.
//
// Usage:
//   Input channel (in_valid / in_stall): one transfer carries mode, level,
//   cell_x/y/z and pos_x/y/z. in_stall is high while an item is in work.
//   Output channel (out_valid / out_stall): one transfer per input item,
//   held in an output register, so the next item may start while a result
//   still waits for the receiver.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): ready is
//   always high; write only while the block is idle.
// Sequence: after the input transfer the sequencer builds the cell size by
//   multiplying the base size by the ratio once per level up to the capped
//   level L, works the three axes in turn, then loads the output register.
//   Per axis: mode 1 multiplies and adds the position; mode 0 subtracts the
//   origin, waits on the 64-step restoring divider and multiplies back; mode 2
//   does both. Mode 3 goes straight to the output register. A new item is
//   taken only once the last one has moved to the output register.
// Reset: config registers return to base_size 1.0, ratio 2, origin zero;
//   the sequencer returns to idle and the output register is emptied.
// Stall: a held result stays stable; a finished item waits in the sequencer
//   until the output register frees, and in_stall stays high meanwhile.
module grid_cell_coordinate_converter_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [7:0]           level,
    input  logic signed [31:0]   cell_x,
    input  logic signed [31:0]   cell_y,
    input  logic signed [31:0]   cell_z,
    input  logic signed [63:0]   pos_x,
    input  logic signed [63:0]   pos_y,
    input  logic signed [63:0]   pos_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           res_level,
    output logic signed [31:0]   res_cell_x,
    output logic signed [31:0]   res_cell_y,
    output logic signed [31:0]   res_cell_z,
    output logic signed [63:0]   res_pos_x,
    output logic signed [63:0]   res_pos_y,
    output logic signed [63:0]   res_pos_z,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int PW = gccc_pkg::POS_W;
    localparam int CW = gccc_pkg::CELL_W;
    localparam int SW = gccc_pkg::SIZE_W;
    localparam int LW = gccc_pkg::LVL_W;
    localparam int AW = PW + CW - 1;

    gccc_pkg::state_t     state_reg, state_next;

    // configuration
    logic [31:0]          base_reg;
    logic [7:0]           ratio_reg;
    logic [PW-1:0]        org_reg [3];

    // item context
    logic [1:0]           mode_reg, mode_next;
    logic [7:0]           level_reg, level_next;
    logic [CW-1:0]        cin_reg [3];
    logic [CW-1:0]        cin_next [3];
    logic [PW-1:0]        pin_reg [3];
    logic [PW-1:0]        pin_next [3];
    logic [LW-1:0]        cap_reg, cap_next;
    logic [LW-1:0]        cnt_reg, cnt_next;
    logic [SW-1:0]        size_reg, size_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [1:0]           ax_reg, ax_next;
    logic [PW-1:0]        abs_reg, abs_next;
    logic [PW-1:0]        d_reg, d_next;
    logic [CW-1:0]        cmag_reg, cmag_next;
    logic                 cneg_reg, cneg_next;
    logic [CW-1:0]        wc_reg [3];
    logic [CW-1:0]        wc_next [3];
    logic [PW-1:0]        wp_reg [3];
    logic [PW-1:0]        wp_next [3];

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    logic [7:0]           olevel_reg;
    logic [CW-1:0]        ocell_reg [3];
    logic [PW-1:0]        opos_reg [3];

    // shared multiplier
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [63:0]          prod;
    logic [AW-1:0]        full;
    logic [PW-1:0]        full_mag;

    // axis selects
    logic [CW-1:0]        cur_cin;
    logic [PW-1:0]        cur_p;
    logic [PW-1:0]        cur_o;
    logic [PW-1:0]        o_mag;
    logic [PW-1:0]        p_mag;
    logic [PW-1:0]        abs_p;
    logic [PW-1:0]        d_val;

    // divider
    logic                 div_start;
    logic                 div_done;
    logic [PW-1:0]        div_q;
    logic [SW-1:0]        div_r;
    logic [PW:0]          q_up;

    gccc_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (d_val[PW-1] ? (~d_val + 1'b1) : d_val),
        .divisor   (size_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign cur_cin = cin_reg[ax_reg];
    assign cur_p   = pin_reg[ax_reg];
    assign cur_o   = org_reg[ax_reg];
    assign o_mag   = cur_o[PW-1] ? (~cur_o + 1'b1) : cur_o;
    assign p_mag   = cur_p[PW-1] ? (~cur_p + 1'b1) : cur_p;
    assign abs_p   = gccc_pkg::sat_add(abs_reg, p_mag, cur_p[PW-1]);
    assign d_val   = gccc_pkg::sat_add(abs_reg, o_mag, !cur_o[PW-1]);
    assign div_start = (state_reg == gccc_pkg::ST_SUB);
    assign q_up    = {1'b0, div_q} + {{PW{1'b0}}, (div_r != '0)};

    // Operand select for the one multiplier: low half, then high half of size.
    always_comb
    begin
        case (state_reg)
            gccc_pkg::ST_SZ_LO:
            begin
                mul_a = {24'd0, ratio_reg};
                mul_b = size_reg[31:0];
            end
            gccc_pkg::ST_SZ_HI:
            begin
                mul_a = {24'd0, ratio_reg};
                mul_b = {1'b0, size_reg[SW-1:32]};
            end
            gccc_pkg::ST_MAC_LO, gccc_pkg::ST_LOC_LO:
            begin
                mul_a = cmag_reg;
                mul_b = size_reg[31:0];
            end
            default:
            begin
                mul_a = cmag_reg;
                mul_b = {1'b0, size_reg[SW-1:32]};
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign full     = acc_reg + {prod[AW-33:0], 32'd0};
    // clamp the product magnitude to 64 bits
    assign full_mag = (|full[AW-1:PW]) ? {PW{1'b1}} : full[PW-1:0];

    assign out_load = (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        level_next     = level_reg;
        cin_next       = cin_reg;
        pin_next       = pin_reg;
        cap_next       = cap_reg;
        cnt_next       = cnt_reg;
        size_next      = size_reg;
        acc_next       = acc_reg;
        ax_next        = ax_reg;
        abs_next       = abs_reg;
        d_next         = d_reg;
        cmag_next      = cmag_reg;
        cneg_next      = cneg_reg;
        wc_next        = wc_reg;
        wp_next        = wp_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            gccc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = mode;
                    level_next  = level;
                    cin_next[0] = cell_x;
                    cin_next[1] = cell_y;
                    cin_next[2] = cell_z;
                    pin_next[0] = pos_x;
                    pin_next[1] = pos_y;
                    pin_next[2] = pos_z;
                    cap_next    = (level < 8'(gccc_pkg::MAX_LEVELS)) ? level[LW-1:0]
                                                                     : LW'(gccc_pkg::MAX_LEVELS - 1);
                    cnt_next    = '0;
                    size_next   = {{(SW-32){1'b0}}, base_reg};
                    ax_next     = '0;
                    if (mode == gccc_pkg::MODE_NONE)
                    begin
                        // undefined mode: all cell and position fields zero
                        for (int i = 0; i < 3; i++)
                        begin
                            wc_next[i] = '0;
                            wp_next[i] = '0;
                        end
                        state_next = gccc_pkg::ST_DONE_W;
                    end
                    else
                        state_next = gccc_pkg::ST_SZ;
                end
            end
            gccc_pkg::ST_SZ:
            begin
                if (cnt_reg == cap_reg)
                begin
                    if (size_reg == '0)
                        size_next = SW'(1);
                    state_next = gccc_pkg::ST_AX;
                end
                else
                    state_next = gccc_pkg::ST_SZ_LO;
            end
            gccc_pkg::ST_SZ_LO:
            begin
                acc_next   = {{(AW-64){1'b0}}, prod};
                state_next = gccc_pkg::ST_SZ_HI;
            end
            gccc_pkg::ST_SZ_HI:
            begin
                // saturate the level size at 2^63-1
                size_next  = (|full[AW-1:SW]) ? {SW{1'b1}} : full[SW-1:0];
                cnt_next   = cnt_reg + 1'b1;
                state_next = gccc_pkg::ST_SZ;
            end
            gccc_pkg::ST_AX:
            begin
                cneg_next = cur_cin[CW-1];
                cmag_next = cur_cin[CW-1] ? (~cur_cin + 1'b1) : cur_cin;
                if (mode_reg == gccc_pkg::MODE_ABS)
                begin
                    abs_next   = cur_p;
                    state_next = gccc_pkg::ST_SUB;
                end
                else
                    state_next = gccc_pkg::ST_MAC_LO;
            end
            gccc_pkg::ST_MAC_LO, gccc_pkg::ST_LOC_LO:
            begin
                acc_next   = {{(AW-64){1'b0}}, prod};
                state_next = (state_reg == gccc_pkg::ST_MAC_LO) ? gccc_pkg::ST_MAC_HI
                                                                : gccc_pkg::ST_LOC_HI;
            end
            gccc_pkg::ST_MAC_HI:
            begin
                abs_next   = gccc_pkg::sat_add(cur_o, full_mag, cneg_reg);
                state_next = gccc_pkg::ST_ADD_P;
            end
            gccc_pkg::ST_ADD_P:
            begin
                if (mode_reg == gccc_pkg::MODE_CELL)
                begin
                    wc_next[ax_reg] = cur_cin;
                    wp_next[ax_reg] = abs_p;
                    ax_next    = ax_reg + 1'b1;
                    state_next = (ax_reg == 2'd2) ? gccc_pkg::ST_DONE_W : gccc_pkg::ST_AX;
                end
                else
                begin
                    abs_next   = abs_p;
                    state_next = gccc_pkg::ST_SUB;
                end
            end
            gccc_pkg::ST_SUB:
            begin
                d_next     = d_val;
                state_next = gccc_pkg::ST_DIV;
            end
            gccc_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = gccc_pkg::ST_CELL;
            end
            gccc_pkg::ST_CELL:
            begin
                // floor: round the magnitude up for negative positions
                cneg_next = d_reg[PW-1];
                if (!d_reg[PW-1])
                    cmag_next = (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[CW-1:0];
                else
                    cmag_next = (q_up > 65'h8000_0000) ? 32'h8000_0000 : q_up[CW-1:0];
                wc_next[ax_reg] = d_reg[PW-1] ? (~cmag_next + 1'b1) : cmag_next;
                state_next = gccc_pkg::ST_LOC_LO;
            end
            gccc_pkg::ST_LOC_HI:
            begin
                wp_next[ax_reg] = gccc_pkg::sat_add(d_reg, full_mag, !cneg_reg);
                ax_next    = ax_reg + 1'b1;
                state_next = (ax_reg == 2'd2) ? gccc_pkg::ST_DONE_W : gccc_pkg::ST_AX;
            end
            gccc_pkg::ST_DONE_W:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = gccc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gccc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gccc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            base_reg      <= 32'd65536;
            ratio_reg     <= 8'd2;
            org_reg[0]    <= '0;
            org_reg[1]    <= '0;
            org_reg[2]    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    gccc_pkg::CFG_BASE:  base_reg   <= cfg_data[31:0];
                    gccc_pkg::CFG_RATIO: ratio_reg  <= cfg_data[7:0];
                    gccc_pkg::CFG_ORG_X: org_reg[0] <= cfg_data;
                    gccc_pkg::CFG_ORG_Y: org_reg[1] <= cfg_data;
                    gccc_pkg::CFG_ORG_Z: org_reg[2] <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        level_reg <= level_next;
        cin_reg   <= cin_next;
        pin_reg   <= pin_next;
        cap_reg   <= cap_next;
        cnt_reg   <= cnt_next;
        size_reg  <= size_next;
        acc_reg   <= acc_next;
        ax_reg    <= ax_next;
        abs_reg   <= abs_next;
        d_reg     <= d_next;
        cmag_reg  <= cmag_next;
        cneg_reg  <= cneg_next;
        wc_reg    <= wc_next;
        wp_reg    <= wp_next;
        if (state_reg == gccc_pkg::ST_DONE_W && out_load)
        begin
            olevel_reg <= level_reg;
            ocell_reg  <= wc_reg;
            opos_reg   <= wp_reg;
        end
    end

    assign in_stall   = (state_reg != gccc_pkg::ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign res_level  = olevel_reg;
    assign res_cell_x = ocell_reg[0];
    assign res_cell_y = ocell_reg[1];
    assign res_cell_z = ocell_reg[2];
    assign res_pos_x  = opos_reg[0];
    assign res_pos_y  = opos_reg[1];
    assign res_pos_z  = opos_reg[2];

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != gccc_pkg::ST_IDLE))
        else $error("accepted item did not start work");
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gccc_pkg::ST_AX) |-> (size_reg != '0))
        else $error("cell size is zero at axis start");
    a_div_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == gccc_pkg::ST_DIV))
        else $error("divider finished outside the wait state");
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gccc_pkg::ST_AX) |-> (ax_reg != 2'd3))
        else $error("axis counter out of range");

endmodule
